FILE: sv/assert_macros.svh
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

    localparam int CMD_W   = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    // control of the edit stage for one sweep cycle
    typedef struct packed {
        logic run;       // sweep in progress, ring and edit stage advance
        logic first;     // priming cycle of a sweep
        logic at_head;   // held entry is the head of the queue
        logic ins_mode;  // insert sweep, else search or remove sweep
        logic rm_pop;    // remove the head regardless of tag
        logic rm_write;  // take the matched entry out of the ring
    } edit_ctrl_t;

endpackage

FILE: sv/sorted_priority_queue.sv
// sorted priority queue top level: ring of cells, edit stage, command sequencer
// sequence: push makes an insert sweep, pop and query a remove sweep, update a remove sweep
//   and, when the tag is found, an insert sweep; a push to a full queue or a pop of an empty one makes none
// flow: one command in flight, the next one is accepted only after the result is loaded into the output register
// reset: async active low, clears all cell valid bits, the entry count and order_mode
`include "assert_macros.svh"
module sorted_priority_queue #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 16,
    parameter int TAG_WIDTH = 16,
    localparam int IN_DATA_W  = ((TAG_WIDTH + KEY_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((TAG_WIDTH + KEY_WIDTH + 3 + spq_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration register order_mode
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    // command stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_DATA_W-1:0]        s_axis_tdata,   // tag, key, zero pad
    input  logic [spq_pkg::CMD_W-1:0]   s_axis_tuser,   // cmd
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata    // ok, tag_out, key_out, present,
                                                        // empty_res, count, zero pad
);

    import spq_pkg::*;

    localparam int ENTRY_W = 1 + TAG_WIDTH + KEY_WIDTH;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REMOVE = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     pass_cnt_reg, pass_cnt_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 order_mode_reg;

    // command and result holding registers
    cmd_t                 cmd_reg, cmd_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 res_present_reg, res_present_next;
    logic [TAG_WIDTH-1:0] res_tag_reg, res_tag_next;
    logic [KEY_WIDTH-1:0] res_key_reg, res_key_next;

    // output register, parts the result side from the command side
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                 in_accept;
    cmd_t                 cmd_in;
    logic [TAG_WIDTH-1:0] tag_in;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 pass_last;
    logic                 queue_full;
    logic                 queue_empty;

    edit_ctrl_t           ctrl;
    logic [ENTRY_W-1:0]   cell_q [CAPACITY];
    logic [ENTRY_W-1:0]   tail_d;
    logic                 edit_found;
    logic [TAG_WIDTH-1:0] edit_hit_tag;
    logic [KEY_WIDTH-1:0] edit_hit_key;

    assign cmd_in = cmd_t'(s_axis_tuser);
    assign tag_in = s_axis_tdata[TAG_WIDTH-1:0];
    assign key_in = s_axis_tdata[TAG_WIDTH +: KEY_WIDTH];

    // a command is taken only between sweeps; a finished result may still wait
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign pass_last   = (pass_cnt_reg == CNT_W'(CAPACITY));
    assign queue_full  = (count_reg == CNT_W'(CAPACITY));
    assign queue_empty = (count_reg == '0);

    // a sweep passes every entry once through the ring of CAPACITY cells plus the edit stage,
    // so every entry comes back to its ranked slot when the sweep ends
    assign ctrl.run      = (state_reg == ST_REMOVE) || (state_reg == ST_INSERT);
    assign ctrl.first    = (pass_cnt_reg == '0);
    assign ctrl.at_head  = (pass_cnt_reg == CNT_W'(1));
    assign ctrl.ins_mode = (state_reg == ST_INSERT);
    assign ctrl.rm_pop   = (cmd_reg == CMD_POP);
    assign ctrl.rm_write = (cmd_reg != CMD_QUERY);

    // ring of cells, head at index 0, the edit stage feeds the tail
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ENTRY_W-1:0] cell_d;
        if (i == CAPACITY - 1)
        begin : g_tail
            assign cell_d = tail_d;
        end
        else
        begin : g_body
            assign cell_d = cell_q[i+1];
        end
        spq_cell #(
            .WIDTH (ENTRY_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ctrl.run),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    spq_edit #(
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_edit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .order_mode (order_mode_reg),
        .op_tag     (tag_reg),
        .op_key     (key_reg),
        .x          (cell_q[0]),
        .y          (tail_d),
        .found      (edit_found),
        .hit_tag    (edit_hit_tag),
        .hit_key    (edit_hit_key)
    );

    // command sequencer
    always_comb
    begin
        state_next       = state_reg;
        pass_cnt_next    = pass_cnt_reg;
        count_next       = count_reg;
        cmd_next         = cmd_reg;
        tag_next         = tag_reg;
        key_next         = key_reg;
        res_ok_next      = res_ok_reg;
        res_present_next = res_present_reg;
        res_tag_next     = res_tag_reg;
        res_key_next     = res_key_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        // result transaction completes
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (ctrl.run)
        begin
            pass_cnt_next = pass_last ? '0 : pass_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next         = cmd_in;
                    tag_next         = tag_in;
                    key_next         = key_in;
                    res_ok_next      = 1'b0;
                    res_present_next = 1'b0;
                    res_tag_next     = '0;
                    res_key_next     = '0;
                    unique case (cmd_in)
                        CMD_PUSH:   state_next = queue_full ? ST_DONE : ST_INSERT;
                        CMD_POP:    state_next = queue_empty ? ST_DONE : ST_REMOVE;
                        CMD_UPDATE: state_next = ST_REMOVE;
                        CMD_QUERY:  state_next = ST_REMOVE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_REMOVE:
            begin
                if (pass_last)
                begin
                    state_next = ST_DONE;
                    unique case (cmd_reg)
                        CMD_POP:
                        begin
                            res_ok_next  = 1'b1;
                            res_tag_next = edit_hit_tag;
                            res_key_next = edit_hit_key;
                            count_next   = count_reg - CNT_W'(1);
                        end
                        CMD_UPDATE:
                        begin
                            // a lone matching entry is re-keyed but reports failure
                            if (edit_found)
                            begin
                                res_ok_next = (count_reg >= CNT_W'(2));
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = ST_INSERT;
                            end
                        end
                        CMD_QUERY:
                        begin
                            res_ok_next      = edit_found;
                            res_present_next = edit_found;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                if (pass_last)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        res_ok_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free or being drained
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({COUNT_W'(count_reg), queue_empty,
                                                res_present_reg, res_key_reg,
                                                res_tag_reg, res_ok_reg});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_cnt_reg   <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            order_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_cnt_reg <= pass_cnt_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we)
            begin
                order_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tag_reg         <= tag_next;
        key_reg         <= key_next;
        res_ok_reg      <= res_ok_next;
        res_present_reg <= res_present_next;
        res_tag_reg     <= res_tag_next;
        res_key_reg     <= res_key_next;
        m_data_reg      <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // while idle, held entries occupy the slots from the head up to the count
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] prefix_vec;
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_chk
        assign valid_vec[i]  = cell_q[i][ENTRY_W-1];
        assign prefix_vec[i] = (CNT_W'(i) < count_reg);
    end

    `SPQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_IMPLY(a_valid_prefix, clk, rst_n, state_reg == ST_IDLE, valid_vec == prefix_vec)
    `SPQ_ASSERT_IMPLY(a_insert_placed, clk, rst_n, ctrl.ins_mode && pass_last, edit_found)
    `SPQ_ASSERT_IMPLY(a_no_accept_in_sweep, clk, rst_n, ctrl.run, !s_axis_tready)

endmodule

FILE: sv/spq_cell.sv
// one storage cell of the queue ring
module spq_cell #(
    parameter int WIDTH = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic             valid_reg;
    logic [WIDTH-2:0] data_reg;

    // valid flag sits in the top bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d[WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d[WIDTH-2:0];
        end
    end

    assign q = {valid_reg, data_reg};

endmodule

FILE: sv/spq_edit.sv
// edit stage that closes the ring: insert, remove or search during a sweep
module spq_edit #(
    parameter int KEY_WIDTH = 16,
    parameter int TAG_WIDTH = 16,
    localparam int ENTRY_W  = 1 + TAG_WIDTH + KEY_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::edit_ctrl_t  ctrl,
    input  logic                 order_mode,
    input  logic [TAG_WIDTH-1:0] op_tag,
    input  logic [KEY_WIDTH-1:0] op_key,
    input  logic [ENTRY_W-1:0]   x,
    output logic [ENTRY_W-1:0]   y,
    output logic                 found,
    output logic [TAG_WIDTH-1:0] hit_tag,
    output logic [KEY_WIDTH-1:0] hit_key
);

    import spq_pkg::*;

    logic [ENTRY_W-1:0]   hold_reg;
    logic [ENTRY_W-1:0]   carry_reg;
    logic                 flag_reg;
    logic                 flag_next;
    logic [TAG_WIDTH-1:0] hit_tag_reg;
    logic [KEY_WIDTH-1:0] hit_key_reg;

    logic                 hold_valid;
    logic [TAG_WIDTH-1:0] hold_tag;
    logic [KEY_WIDTH-1:0] hold_key;
    logic                 new_beats_hold;
    logic                 hold_beats_new;
    logic                 place_here;
    logic                 match_now;

    assign hold_valid = hold_reg[ENTRY_W-1];
    assign hold_tag   = hold_reg[KEY_WIDTH +: TAG_WIDTH];
    assign hold_key   = hold_reg[KEY_WIDTH-1:0];

    assign new_beats_hold = order_mode ? (op_key < hold_key) : (op_key > hold_key);
    assign hold_beats_new = order_mode ? (hold_key < op_key) : (hold_key > op_key);

    // head: go in front only when strictly ahead; later: stop at first entry not ahead
    assign place_here = !hold_valid || (ctrl.at_head ? new_beats_hold : !hold_beats_new);
    assign match_now  = !ctrl.ins_mode && !flag_reg && hold_valid
                        && (ctrl.rm_pop || (hold_tag == op_tag));

    always_comb
    begin
        y         = hold_reg;
        flag_next = flag_reg;
        if (ctrl.first)
        begin
            y         = '0;
            flag_next = 1'b0;
        end
        else if (ctrl.ins_mode)
        begin
            if (!flag_reg && place_here)
            begin
                y         = {1'b1, op_tag, op_key};
                flag_next = 1'b1;
            end
            else if (flag_reg)
            begin
                y = carry_reg;
            end
        end
        else
        begin
            flag_next = flag_reg || match_now;
            // once the match is dropped every later entry moves up by one
            if (ctrl.rm_write && (flag_reg || match_now))
            begin
                y = x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctrl.run)
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            hold_reg  <= x;
            carry_reg <= hold_reg;
            if (match_now && !ctrl.first)
            begin
                hit_tag_reg <= hold_tag;
                hit_key_reg <= hold_key;
            end
        end
    end

    assign found   = flag_next;
    assign hit_tag = match_now ? hold_tag : hit_tag_reg;
    assign hit_key = match_now ? hold_key : hit_key_reg;

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench of the sorted priority queue with its own ranked-list predictor
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int CAP        = 16;
    localparam int KEY_W      = 16;
    localparam int TAG_W      = 16;
    localparam int IN_DATA_W  = ((TAG_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((TAG_W + KEY_W + 3 + COUNT_W + 7) / 8) * 8;
    localparam int SHOWN_MAX  = 10;

    // one queue command as it travels on the slave side
    typedef struct {
        cmd_t             cmd;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } queue_cmd_t;

    // one answer as it travels on the master side, fields from the msb down
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               present;
        logic [KEY_W-1:0]   key_out;
        logic [TAG_W-1:0]   tag_out;
        logic               ok;
    } answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // tag, key
    logic [CMD_W-1:0]      s_axis_tuser = '0;    // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // ok, tag_out, key_out, present,
                                                 // empty_res, count, zero pad

    sorted_priority_queue #(
        .CAPACITY  (CAP),
        .KEY_WIDTH (KEY_W),
        .TAG_WIDTH (TAG_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // ranked list predictor: own copy of the entries and of order_mode
    // ------------------------------------------------------------------
    logic             serve_smallest = 1'b0;   // tracks order_mode
    logic [KEY_W-1:0] rank_key [CAP];
    logic [TAG_W-1:0] rank_tag [CAP];
    int               rank_len = 0;

    function automatic bit ranks_above(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return serve_smallest ? (a < b) : (a > b);
    endfunction

    // new entry goes behind every later entry that strictly outranks it;
    // it only displaces the head when it strictly outranks the head
    function automatic bit rank_insert(logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
        int slot;
        if (rank_len >= CAP)
            return 1'b0;
        if (rank_len == 0 || ranks_above(key, rank_key[0]))
            slot = 0;
        else
        begin
            slot = 1;
            while (slot < rank_len && ranks_above(rank_key[slot], key))
                slot++;
        end
        for (int i = rank_len; i > slot; i--)
        begin
            rank_key[i] = rank_key[i-1];
            rank_tag[i] = rank_tag[i-1];
        end
        rank_key[slot] = key;
        rank_tag[slot] = tag;
        rank_len++;
        return 1'b1;
    endfunction

    function automatic void rank_remove(int slot);
        for (int i = slot; i + 1 < rank_len; i++)
        begin
            rank_key[i] = rank_key[i+1];
            rank_tag[i] = rank_tag[i+1];
        end
        rank_len--;
    endfunction

    // first match from the head, -1 when absent
    function automatic int rank_find(logic [TAG_W-1:0] tag);
        for (int i = 0; i < rank_len; i++)
            if (rank_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // apply one command to the predicted list and build the answer it yields
    function automatic answer_t queue_apply(cmd_t cmd, logic [TAG_W-1:0] tag,
                                            logic [KEY_W-1:0] key);
        answer_t ans;
        int      slot;
        ans = '0;
        case (cmd)
            CMD_PUSH:
                ans.ok = rank_insert(tag, key);
            CMD_UPDATE:
            begin
                slot = rank_find(tag);
                if (slot >= 0)
                begin
                    // a lone matching entry is re-keyed but reported as a failure
                    if (rank_len < 2)
                        rank_key[slot] = key;
                    else
                    begin
                        rank_remove(slot);
                        ans.ok = rank_insert(tag, key);
                    end
                end
            end
            CMD_POP:
                if (rank_len > 0)
                begin
                    ans.tag_out = rank_tag[0];
                    ans.key_out = rank_key[0];
                    rank_remove(0);
                    ans.ok = 1'b1;
                end
            default:
            begin
                ans.present = (rank_find(tag) >= 0);
                ans.ok      = ans.present;
            end
        endcase
        ans.empty_res = (rank_len == 0);
        ans.count     = rank_len[COUNT_W-1:0];
        return ans;
    endfunction

    function automatic string show_answer(answer_t a);
        return $sformatf("ok=%0d tag=%h key=%h present=%0d empty=%0d count=%0d",
                         a.ok, a.tag_out, a.key_out, a.present, a.empty_res, a.count);
    endfunction

    // ------------------------------------------------------------------
    // failure bookkeeping
    // ------------------------------------------------------------------
    int fail_count = 0;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= SHOWN_MAX)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // command driver: falling edge, fed from cmd_queue
    // ------------------------------------------------------------------
    queue_cmd_t cmd_queue [$];
    queue_cmd_t cmd_cur;
    bit         holding     = 1'b0;  // a command is on the bus
    int         sent_total  = 0;     // commands put on the bus, driver side
    int         taken_total = 0;     // command transactions seen, monitor side
    int         gap_left    = 0;
    int         gap_max     = 7;     // per-phase idling bound of the sender
    int         stall_max   = 7;     // per-phase stall bound of the receiver
    int         stall_left  = 0;
    int         result_total = 0;    // result transactions seen, monitor side
    int         result_seen  = 0;    // results already given a stall draw

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            // the command on the bus went through at the last rising edge
            if (holding && taken_total == sent_total)
                holding = 1'b0;
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() != 0)
                begin
                    cmd_cur  = cmd_queue.pop_front();
                    holding  = 1'b1;
                    sent_total++;
                    // idle cycles ahead of the following command
                    gap_left = $urandom_range(0, gap_max);
                end
            end
            s_axis_tvalid <= holding;
            if (holding)
            begin
                s_axis_tdata <= {cmd_cur.key, cmd_cur.tag};
                s_axis_tuser <= cmd_cur.cmd;
            end
        end
    end

    // result backpressure: hold tready low for the drawn number of cycles
    // while a result is waiting
    always @(negedge clk)
    begin
        if (result_seen != result_total)
        begin
            result_seen = result_total;
            stall_left  = $urandom_range(0, stall_max);
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            if (m_axis_tvalid)
                stall_left--;
        end
        else
            m_axis_tready <= rst_n;
    end

    // ------------------------------------------------------------------
    // monitor: rising edge, predicts on each command transaction and
    // checks each result transaction against the oldest expectation
    // ------------------------------------------------------------------
    answer_t answers_due [$];
    answer_t ans_seen;
    answer_t ans_want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due.push_back(queue_apply(cmd_t'(s_axis_tuser),
                                                  s_axis_tdata[TAG_W-1:0],
                                                  s_axis_tdata[TAG_W+KEY_W-1:TAG_W]));
                taken_total++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                ans_seen = m_axis_tdata[$bits(answer_t)-1:0];
                if (answers_due.size() == 0)
                    note_failure({"result with nothing expected: ", show_answer(ans_seen)});
                else
                begin
                    ans_want = answers_due.pop_front();
                    if (ans_seen !== ans_want)
                        note_failure({"result mismatch\n  expected ", show_answer(ans_want),
                                      "\n  actual   ", show_answer(ans_seen)});
                end
                result_total++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_cmd(cmd_t cmd, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
        queue_cmd_t c;
        c.cmd = cmd;
        c.tag = tag;
        c.key = key;
        cmd_queue.push_back(c);
    endtask

    // wait until every command is sent and every result has come back
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || holding || answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_order(logic smallest_first);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= smallest_first;
        @(negedge clk);
        cfg_we    <= 1'b0;
        serve_smallest = smallest_first;
    endtask

    // mix: 0 balanced, 1 mostly pushes (reaches full), 2 mostly pops (reaches empty)
    task automatic add_random(int n, int mix);
        logic [TAG_W-1:0] tag_base;
        logic [KEY_W-1:0] key_base;
        int               r;
        cmd_t             cmd;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        tag_base = TAG_W'($urandom);
        key_base = KEY_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            case (mix)
                1:       cmd = (r < 60) ? CMD_PUSH : (r < 75) ? CMD_UPDATE :
                               (r < 85) ? CMD_POP  : CMD_QUERY;
                2:       cmd = (r < 20) ? CMD_PUSH : (r < 35) ? CMD_UPDATE :
                               (r < 80) ? CMD_POP  : CMD_QUERY;
                default: cmd = (r < 35) ? CMD_PUSH : (r < 55) ? CMD_UPDATE :
                               (r < 80) ? CMD_POP  : CMD_QUERY;
            endcase
            // a small tag pool so updates and queries mostly find their tag
            tag = ($urandom_range(0, 99) < 85) ? TAG_W'(tag_base + $urandom_range(0, 7))
                                                : TAG_W'($urandom);
            // keys: clustered for ties, extremes, or anything
            r = $urandom_range(0, 99);
            if (r < 40)
                key = KEY_W'(key_base + $urandom_range(0, 3));
            else if (r < 60)
                key = $urandom_range(0, 1) ? '1 : '0;
            else
                key = KEY_W'($urandom);
            add_cmd(cmd, tag, key);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed part, largest key first
        add_cmd(CMD_POP,    16'h0000, 16'h0000);   // pop of an empty queue
        add_cmd(CMD_UPDATE, 16'h0005, 16'h0007);   // update on an empty queue
        add_cmd(CMD_QUERY,  16'h0005, 16'h0000);   // query on an empty queue
        add_cmd(CMD_PUSH,   16'h0000, 16'h0000);
        add_cmd(CMD_UPDATE, 16'h0000, 16'hffff);   // lone entry re-keyed, still fails
        add_cmd(CMD_QUERY,  16'h0000, 16'h0000);
        add_cmd(CMD_PUSH,   16'hffff, 16'hffff);   // ties with the head, goes behind it
        add_cmd(CMD_PUSH,   16'h0001, 16'h0005);
        add_cmd(CMD_PUSH,   16'h0002, 16'h0005);   // ties a later entry, goes in front
        add_cmd(CMD_PUSH,   16'h0003, 16'hffff);
        add_cmd(CMD_PUSH,   16'h0001, 16'h0009);   // duplicate tag
        add_cmd(CMD_UPDATE, 16'h0001, 16'h0000);   // first match from the head moves
        add_cmd(CMD_UPDATE, 16'h1234, 16'h0008);   // absent tag
        add_cmd(CMD_QUERY,  16'h0001, 16'h0000);
        add_cmd(CMD_QUERY,  16'habcd, 16'h0000);
        add_cmd(CMD_PUSH,   16'haaaa, 16'h5555);
        add_cmd(CMD_PUSH,   16'h5555, 16'haaaa);
        add_cmd(CMD_UPDATE, 16'h5555, 16'hffff);   // new key ties the head, goes in right behind it
        add_cmd(CMD_POP,    16'h0000, 16'h0000);
        add_cmd(CMD_POP,    16'h0000, 16'h0000);
        wait_drained();

        // random phases, order alternating, some phases without any idling
        for (int phase = 0; phase < 8; phase++)
        begin
            write_order(phase % 2 == 0);
            gap_max   = (phase % 4 == 3) ? 0 : 7;
            stall_max = (phase % 4 == 3 || phase == 5) ? 0 : 7;
            add_random(40, 1);
            add_random(60, phase % 3);
            add_random(40, 2);
            wait_drained();
        end

        // let any stray result show up
        repeat (40) @(posedge clk);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_edit.sv
sv/sorted_priority_queue.sv
tb/sv/tb.sv
